// ----- design/cpba_pkg.sv -----
// Shared constants, codes and types for the contiguous page bitmap allocator.
package cpba_pkg;

  localparam int POOL_PAGES      = 4096;
  localparam int PAGE_SHIFT_BITS = 12;

  localparam int WORD_BITS = 64;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int LEN_W     = BIT_W + 1;
  localparam int MAP_WORDS = POOL_PAGES / WORD_BITS;
  localparam int IDX_W     = $clog2(POOL_PAGES);
  localparam int WORD_W    = IDX_W - BIT_W;

  localparam int ADDR_W     = 64;
  localparam int BASE_W     = 48;
  localparam int WIN_W      = 16;
  localparam int CNT_W      = 13;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd1;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'h9000;

  // Per-word scan decision handed back to the controller.
  typedef struct packed {
    logic              vld;
    logic [WORD_W-1:0] tag;
    logic              found;
    logic [BIT_W-1:0]  hit_bit;
    logic              all_free;
    logic [LEN_W-1:0]  top_free;
  } scan_res_t;

endpackage

// ----- design/cpba_map_ram.sv -----
// Bitmap word RAM: one write port, one registered read port, per-row valid bits.
module cpba_map_ram (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 re_i,
  input  logic [cpba_pkg::WORD_W-1:0]          raddr_i,
  input  logic                                 we_i,
  input  logic [cpba_pkg::WORD_W-1:0]          waddr_i,
  input  logic [cpba_pkg::WORD_BITS-1:0]       wdata_i,
  output logic [cpba_pkg::WORD_BITS-1:0]       rdata_o
);
  import cpba_pkg::*;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic [MAP_WORDS-1:0] row_vld_q;
  logic                 rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // A row never written reads as all free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rvld_q    <= 1'b0;
    end else begin
      if (we_i) begin
        row_vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= row_vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ----- design/cpba_word_scan.sv -----
// Two-stage free-run scan of one bitmap word: prefix stage, then threshold match.
module cpba_word_scan (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           vld_i,
  input  logic [cpba_pkg::WORD_W-1:0]    tag_i,
  input  logic [cpba_pkg::WORD_BITS-1:0] word_i,
  input  logic [cpba_pkg::CNT_W-1:0]     need_i,
  input  logic [cpba_pkg::CNT_W-1:0]     count_i,
  output cpba_pkg::scan_res_t            res_o
);
  import cpba_pkg::*;

  localparam int LEVELS = BIT_W;

  logic                 lu_vld [LEVELS+1][WORD_BITS];
  logic [BIT_W-1:0]     lu_pos [LEVELS+1][WORD_BITS];
  logic [LEN_W-1:0]     len_d  [WORD_BITS];
  logic [LEN_W-1:0]     len_q  [WORD_BITS];
  logic                 s1_vld_q;
  logic [WORD_W-1:0]    s1_tag_q;
  logic [WORD_BITS-1:0] hit;
  logic [WORD_BITS-1:0] first;
  logic [BIT_W-1:0]     hit_bit;

  // Stage 1: position of the last used bit at or below each bit (log prefix).
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      lu_vld[0][j] = word_i[j];
      lu_pos[0][j] = BIT_W'(j);
    end
    for (int l = 0; l < LEVELS; l++) begin
      for (int j = 0; j < WORD_BITS; j++) begin
        if (j >= (1 << l) && !lu_vld[l][j]) begin
          lu_vld[l+1][j] = lu_vld[l][j - (1 << l)];
          lu_pos[l+1][j] = lu_pos[l][j - (1 << l)];
        end else begin
          lu_vld[l+1][j] = lu_vld[l][j];
          lu_pos[l+1][j] = lu_pos[l][j];
        end
      end
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      len_d[j] = lu_vld[LEVELS][j] ? LEN_W'(j) - LEN_W'(lu_pos[LEVELS][j]) : LEN_W'(j + 1);
    end
  end

  always_ff @(posedge clk_i) begin
    len_q    <= len_d;
    s1_tag_q <= tag_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= vld_i;
    end
  end

  // Stage 2: a run open from the word's bottom continues the carried run.
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      if (len_q[j] == LEN_W'(j + 1)) begin
        hit[j] = CNT_W'(len_q[j]) >= need_i;
      end else begin
        hit[j] = CNT_W'(len_q[j]) >= count_i;
      end
    end
    first = hit & (~hit + WORD_BITS'(1));
    for (int b = 0; b < BIT_W; b++) begin
      hit_bit[b] = 1'b0;
      for (int j = 0; j < WORD_BITS; j++) begin
        hit_bit[b] = hit_bit[b] | (first[j] & ((j >> b) & 1) == 1);
      end
    end
  end

  assign res_o.vld      = s1_vld_q;
  assign res_o.tag      = s1_tag_q;
  assign res_o.found    = |hit;
  assign res_o.hit_bit  = hit_bit;
  assign res_o.all_free = len_q[WORD_BITS-1] == LEN_W'(WORD_BITS);
  assign res_o.top_free = len_q[WORD_BITS-1];

endmodule

// ----- design/contiguous_page_bitmap_allocator.sv -----
// Top level: first-fit contiguous page allocator with bitmap RAM and control.
//
// One item at a time: busy is high from the cycle after start is taken up to
// the cycle before the result strobe done_o; busy is already low while done_o
// is shown. The result (granted_address_o, status_o) is valid for exactly
// that one cycle and cannot be held off; a new item may be started in that
// same cycle. The bitmap lives in a 64 x 64-bit RAM with one read and one
// write port; the scan reads one word per cycle and a two-stage word scanner
// decides one word per cycle behind it. A zero or oversize allocate count is
// refused with no room without raising busy; an allocate scans the words in
// order until a run fits and then marks the run's words, and one that finds
// no room scans every word; a free is range checked first and, if in range,
// clears its run's words. Rows never written read as free, so there is no
// clearing pass after reset. Configuration writes (always ready) are only
// meant while the block is idle.
module contiguous_page_bitmap_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            operation_i,
  input  logic [cpba_pkg::CNT_W-1:0]      page_count_i,
  input  logic [cpba_pkg::ADDR_W-1:0]     release_address_i,
  output logic                            done_o,
  output logic [cpba_pkg::ADDR_W-1:0]     granted_address_o,
  output logic [cpba_pkg::STATUS_W-1:0]   status_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cpba_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cpba_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import cpba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FSUB,
    S_FCHK,
    S_MSET,
    S_MARK
  } state_e;

  localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MAP_WORDS - 1);

  state_e              state_q;
  logic [BASE_W-1:0]   pool_base_q;
  logic [WIN_W-1:0]    window_q;

  // captured item
  op_e                 op_q;
  logic [CNT_W-1:0]    count_q;
  logic [ADDR_W-1:0]   addr_q;

  // scan
  logic [WORD_W-1:0]   iss_q;
  logic                iss_done_q;
  logic                sc_vld_q;
  logic [WORD_W-1:0]   sc_tag_q;
  logic [CNT_W-1:0]    need_q;
  scan_res_t           scan_res;

  // run bounds and marking
  logic [ADDR_W-1:0]   diff_q;
  logic [IDX_W-1:0]    start_q;
  logic [IDX_W-1:0]    end_q;
  logic [WORD_W-1:0]   mk_q;
  logic                mk_done_q;
  logic                mk_vld_q;
  logic [WORD_W-1:0]   mk_tag_q;

  // results
  logic                done_q;
  logic [ADDR_W-1:0]   granted_q;
  status_e             status_q;

  // RAM ports
  logic                ram_re;
  logic [WORD_W-1:0]   ram_raddr;
  logic                ram_we;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] mark_mask;
  logic [BIT_W-1:0]    mask_lo;
  logic [BIT_W-1:0]    mask_hi;

  logic                accept;
  logic                count_bad;
  logic                free_ok;
  logic [IDX_W-1:0]    start_calc;
  logic [ADDR_W-1:0]   alloc_addr;

  assign accept      = start && !busy;
  assign busy        = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;

  assign count_bad = (page_count_i == '0) || (32'(page_count_i) > 32'(POOL_PAGES));

  // free range: start index inside the pool and the run ends inside it too
  assign free_ok = (count_q != '0) &&
                   (diff_q[ADDR_W-1:PAGE_SHIFT_BITS+IDX_W] == '0) &&
                   (32'(count_q) <= 32'(POOL_PAGES) -
                                    32'(diff_q[PAGE_SHIFT_BITS +: IDX_W]));

  assign start_calc = IDX_W'(32'(end_q) + 32'd1 - 32'(count_q));

  assign alloc_addr = {window_q, {BASE_W{1'b0}}} |
                      (ADDR_W'(pool_base_q) + (ADDR_W'(start_q) << PAGE_SHIFT_BITS));

  // RAM read port: scan words in order, or walk the run's words for marking
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = iss_q;
    if (state_q == S_SCAN && !iss_done_q) begin
      ram_re    = 1'b1;
      ram_raddr = iss_q;
    end else if (state_q == S_MARK && !mk_done_q) begin
      ram_re    = 1'b1;
      ram_raddr = mk_q;
    end
  end

  // read-modify-write of one run word; first and last word are partial
  always_comb begin
    mask_lo   = (mk_tag_q == start_q[IDX_W-1:BIT_W]) ? start_q[BIT_W-1:0] : '0;
    mask_hi   = (mk_tag_q == end_q[IDX_W-1:BIT_W]) ? end_q[BIT_W-1:0] : '1;
    mark_mask = ({WORD_BITS{1'b1}} << mask_lo) &
                ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - mask_hi));
    ram_we    = state_q == S_MARK && mk_vld_q;
    ram_wdata = (op_q == OP_FREE) ? (ram_rdata & ~mark_mask) : (ram_rdata | mark_mask);
  end

  cpba_map_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .we_i    (ram_we),
    .waddr_i (mk_tag_q),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  cpba_word_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (sc_vld_q),
    .tag_i   (sc_tag_q),
    .word_i  (ram_rdata),
    .need_i  (need_q),
    .count_i (count_q),
    .res_o   (scan_res)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
      window_q    <= WINDOW_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_POOL_BASE: pool_base_q <= cfg_data_i[BASE_W-1:0];
        CFG_WINDOW:    window_q    <= cfg_data_i[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_e'(operation_i);
      count_q <= page_count_i;
      addr_q  <= release_address_i;
    end
    if (state_q == S_FSUB) begin
      diff_q <= (addr_q & ~{window_q, {BASE_W{1'b0}}}) - ADDR_W'(pool_base_q);
    end
  end

  // control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      iss_q      <= '0;
      iss_done_q <= 1'b0;
      sc_vld_q   <= 1'b0;
      sc_tag_q   <= '0;
      need_q     <= '0;
      start_q    <= '0;
      end_q      <= '0;
      mk_q       <= '0;
      mk_done_q  <= 1'b1;
      mk_vld_q   <= 1'b0;
      mk_tag_q   <= '0;
      done_q     <= 1'b0;
      granted_q  <= '0;
      status_q   <= ST_DONE;
    end else begin
      done_q   <= 1'b0;
      sc_vld_q <= state_q == S_SCAN && !iss_done_q;
      sc_tag_q <= iss_q;
      mk_vld_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            iss_q      <= '0;
            iss_done_q <= 1'b0;
            need_q     <= page_count_i;
            if (operation_i == OP_FREE) begin
              state_q <= S_FSUB;
            end else if (count_bad) begin
              done_q    <= 1'b1;
              granted_q <= '0;
              status_q  <= ST_NO_ROOM;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (!iss_done_q) begin
            iss_q      <= iss_q + WORD_W'(1);
            iss_done_q <= iss_q == LAST_WORD;
          end
          if (scan_res.vld) begin
            if (scan_res.found) begin
              end_q   <= {scan_res.tag, scan_res.hit_bit};
              state_q <= S_MSET;
            end else if (scan_res.tag == LAST_WORD) begin
              done_q    <= 1'b1;
              granted_q <= '0;
              status_q  <= ST_NO_ROOM;
              state_q   <= S_IDLE;
            end else if (scan_res.all_free) begin
              need_q <= need_q - CNT_W'(WORD_BITS);
            end else begin
              need_q <= count_q - CNT_W'(scan_res.top_free);
            end
          end
        end

        S_FSUB: begin
          state_q <= S_FCHK;
        end

        S_FCHK: begin
          if (free_ok) begin
            end_q   <= IDX_W'(32'(diff_q[PAGE_SHIFT_BITS +: IDX_W]) + 32'(count_q) - 32'd1);
            state_q <= S_MSET;
          end else begin
            done_q    <= 1'b1;
            granted_q <= '0;
            status_q  <= ST_RANGE;
            state_q   <= S_IDLE;
          end
        end

        S_MSET: begin
          start_q   <= start_calc;
          mk_q      <= start_calc[IDX_W-1:BIT_W];
          mk_done_q <= 1'b0;
          state_q   <= S_MARK;
        end

        S_MARK: begin
          if (!mk_done_q) begin
            mk_vld_q  <= 1'b1;
            mk_tag_q  <= mk_q;
            mk_q      <= mk_q + WORD_W'(1);
            mk_done_q <= mk_q == end_q[IDX_W-1:BIT_W];
          end
          if (mk_vld_q && mk_tag_q == end_q[IDX_W-1:BIT_W]) begin
            done_q    <= 1'b1;
            granted_q <= (op_q == OP_ALLOC) ? alloc_addr : '0;
            status_q  <= ST_DONE;
            state_q   <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o            = done_q;
  assign granted_address_o = granted_q;
  assign status_o          = status_q;

  // RMW walk never reads the word it is writing back
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && ram_re |-> ram_raddr != mk_tag_q)
    else $error("map RAM read and write hit the same word");

  // bitmap only changes while marking a run
  a_write_in_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == S_MARK)
    else $error("map RAM written outside the mark walk");

  // the result strobe comes with the block already idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy)
    else $error("result strobe while still busy");

  // only a successful allocate returns an address
  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (status_q != ST_DONE || op_q == OP_FREE) |-> granted_q == '0)
    else $error("address returned on failure or free");

  // the marked run never starts after it ends
  a_run_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MARK |-> start_q <= end_q)
    else $error("run start beyond run end");

endmodule

// ----- dv/page_grant_checker.sv -----
// Checker for the page allocator: predicts each grant and compares results.
`timescale 1ns / 100ps

module page_grant_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  logic                            operation_i,
  input  logic [cpba_pkg::CNT_W-1:0]      page_count_i,
  input  logic [cpba_pkg::ADDR_W-1:0]     release_address_i,
  input  logic                            done_i,
  input  logic [cpba_pkg::ADDR_W-1:0]     granted_address_i,
  input  logic [cpba_pkg::STATUS_W-1:0]   status_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [cpba_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cpba_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              err_count_o,
  output int                              pending_o,
  output int                              item_count_o,
  output int                              grant_count_o,
  output int                              no_room_count_o,
  output int                              range_count_o,
  output int                              write_count_o
);
  import cpba_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_e           st;
  } grant_t;

  // Shadow of the block: page map and the two registers.
  logic [POOL_PAGES-1:0] page_used = '0;
  logic [BASE_W-1:0]     pool_base = '0;
  logic [WIN_W-1:0]      window_hi = WINDOW_RESET;

  grant_t grants_due[$];
  grant_t due;

  // First-fit search on allocate, range check and clear on free.
  function automatic grant_t serve_item(op_e op, logic [CNT_W-1:0] cnt,
                                        logic [ADDR_W-1:0] addr);
    grant_t            res;
    int unsigned       n;
    int unsigned       run;
    int unsigned       first;
    bit                found;
    logic [ADDR_W-1:0] win_mask;
    logic [ADDR_W-1:0] page_idx;
    res.addr = '0;
    res.st   = ST_DONE;
    n        = cnt;
    win_mask = {window_hi, {BASE_W{1'b0}}};
    if (op == OP_ALLOC) begin
      found = 1'b0;
      run   = 0;
      first = 0;
      if (n != 0 && n <= POOL_PAGES) begin
        for (int i = 0; i < POOL_PAGES; i++) begin
          if (page_used[i]) begin
            run = 0;
          end else begin
            if (run == 0) first = i;
            run++;
            if (run == n) begin
              found = 1'b1;
              break;
            end
          end
        end
      end
      if (found) begin
        for (int i = 0; i < n; i++) page_used[first + i] = 1'b1;
        res.addr = win_mask | ({{(ADDR_W-BASE_W){1'b0}}, pool_base} +
                               (64'(first) << PAGE_SHIFT_BITS));
      end else begin
        res.st = ST_NO_ROOM;
      end
    end else begin
      // wraps to a huge index when the address sits below the pool
      page_idx = ((addr & ~win_mask) - {{(ADDR_W-BASE_W){1'b0}}, pool_base})
                 >> PAGE_SHIFT_BITS;
      if (n == 0 || page_idx >= POOL_PAGES ||
          64'(n) > 64'(POOL_PAGES) - page_idx) begin
        res.st = ST_RANGE;
      end else begin
        for (int i = 0; i < n; i++) page_used[int'(page_idx) + i] = 1'b0;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_used       = '0;
      pool_base       = '0;
      window_hi       = WINDOW_RESET;
      grants_due.delete();
      err_count_o     = 0;
      item_count_o    = 0;
      grant_count_o   = 0;
      no_room_count_o = 0;
      range_count_o   = 0;
      write_count_o   = 0;
    end else begin
      // result of the previous item first, then a new item on the same edge
      if (done_i) begin
        if (grants_due.size() == 0) begin
          err_count_o++;
          if (err_count_o <= 10)
            $display("ERROR: result with nothing pending: addr %h status %0d",
                     granted_address_i, status_i);
        end else begin
          due = grants_due.pop_front();
          if (granted_address_i !== due.addr || status_i !== due.st) begin
            err_count_o++;
            if (err_count_o <= 10)
              $display("ERROR: grant mismatch: expected addr %h status %s, got addr %h status %0d",
                       due.addr, due.st.name(), granted_address_i, status_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        write_count_o++;
        case (cfg_index_i)
          CFG_POOL_BASE: pool_base = cfg_data_i[BASE_W-1:0];
          CFG_WINDOW:    window_hi = cfg_data_i[WIN_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        due = serve_item(op_e'(operation_i), page_count_i, release_address_i);
        grants_due.push_back(due);
        item_count_o++;
        case (due.st)
          ST_DONE:    if (operation_i == OP_ALLOC) grant_count_o++;
          ST_NO_ROOM: no_room_count_o++;
          default:    range_count_o++;
        endcase
      end
    end
    pending_o = grants_due.size();
  end

endmodule

// ----- dv/contiguous_page_bitmap_allocator_test.sv -----
// Testbench top for the page allocator: stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module contiguous_page_bitmap_allocator_test;
  import cpba_pkg::*;

  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 400;   // random items per register setting
  localparam int IDLE_PCT    = 22;    // sender gap chance per cycle
  localparam int END_PAUSE   = 200;   // longer than the slowest alloc plus mark
  localparam int STALL_LIMIT = 4000;  // cycles with no handshake at all

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  operation;
  logic [CNT_W-1:0]      page_count;
  logic [ADDR_W-1:0]     release_address;
  logic                  done;
  logic [ADDR_W-1:0]     granted_address;
  logic [STATUS_W-1:0]   status;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int err_count;
  int pending;
  int item_count;
  int grant_count;
  int no_room_count;
  int range_count;
  int write_count;
  int quiet_cycles = 0;

  // Runs currently held, learned from grants; used to build sane frees.
  typedef struct {
    logic [ADDR_W-1:0] base_addr;
    int unsigned       pages;
  } run_t;

  typedef struct {
    op_e         op;
    int unsigned pages;
  } issue_t;

  run_t   held_runs[$];
  issue_t in_flight[$];
  issue_t last_issue;

  // Current register values as the stimulus side sees them.
  logic [BASE_W-1:0] cur_base;
  logic [WIN_W-1:0]  cur_win;

  contiguous_page_bitmap_allocator dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .start             (start),
    .busy              (busy),
    .operation_i       (operation),
    .page_count_i      (page_count),
    .release_address_i (release_address),
    .done_o            (done),
    .granted_address_o (granted_address),
    .status_o          (status),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  page_grant_checker grant_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .start_i           (start),
    .busy_i            (busy),
    .operation_i       (operation),
    .page_count_i      (page_count),
    .release_address_i (release_address),
    .done_i            (done),
    .granted_address_i (granted_address),
    .status_i          (status),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .err_count_o       (err_count),
    .pending_o         (pending),
    .item_count_o      (item_count),
    .grant_count_o     (grant_count),
    .no_room_count_o   (no_room_count),
    .range_count_o     (range_count),
    .write_count_o     (write_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: any item, result or register write counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Track grants so later frees can name runs that are really held.
  // Only one item is in flight; a result and a new item may share an edge,
  // so the result is retired before the new item is recorded.
  always @(posedge clk) begin
    if (done && in_flight.size() > 0) begin
      last_issue = in_flight.pop_front();
      if (last_issue.op == OP_ALLOC && status == ST_DONE)
        held_runs.push_back('{granted_address, last_issue.pages});
    end
    if (rst_n && start && !busy)
      in_flight.push_back('{op_e'(operation), 32'(page_count)});
  end

  // Mapped address of a pool page under the current registers.
  function automatic logic [ADDR_W-1:0] page_addr(int unsigned page);
    return {cur_win, {BASE_W{1'b0}}} |
           ({{(ADDR_W-BASE_W){1'b0}}, cur_base} + (64'(page) << PAGE_SHIFT_BITS));
  endfunction

  // Present one item at the falling edge and hold it until taken. With
  // quiet set, start stays high back to back so items follow results
  // without a gap.
  task automatic drive_item(input op_e op, input int unsigned cnt,
                            input logic [ADDR_W-1:0] addr, input bit quiet);
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        start = 1'b0;
        @(negedge clk);
      end
    end
    start           = 1'b1;
    operation       = op;
    page_count      = cnt[CNT_W-1:0];
    release_address = addr;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Wait until every expected result is back; the block is then idle.
  task automatic settle();
    start = 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(negedge clk);
  endtask

  // Hand-picked items around the corners of the search and the free check.
  // Expects an empty pool, pool_base page aligned.
  task automatic run_directed();
    drive_item(OP_ALLOC, 0, '0, 1'b0);             // zero pages
    drive_item(OP_ALLOC, POOL_PAGES + 1, '0, 1'b0); // just past the pool
    drive_item(OP_ALLOC, 8191, '1, 1'b0);           // widest count
    drive_item(OP_ALLOC, 1, '0, 1'b0);              // page 0
    drive_item(OP_ALLOC, POOL_PAGES - 1, '0, 1'b0); // fills the rest
    drive_item(OP_ALLOC, 1, '0, 1'b0);              // pool full
    drive_item(OP_FREE, 0, page_addr(0), 1'b0);     // free of zero pages
    drive_item(OP_FREE, 1, page_addr(0), 1'b0);
    drive_item(OP_ALLOC, POOL_PAGES, '0, 1'b0);     // one hole is not enough
    drive_item(OP_FREE, 2, page_addr(POOL_PAGES - 1), 1'b0); // runs off the end
    drive_item(OP_FREE, 1, page_addr(POOL_PAGES), 1'b0);     // start past end
    // below the pool base: wraps to a huge index
    drive_item(OP_FREE, 1, {{(ADDR_W-BASE_W){1'b0}}, cur_base} - 64'h1000, 1'b0);
    // window bits dropped and page offset garbage: both ignored
    drive_item(OP_FREE, 100,
               (page_addr(1) & ~{cur_win, {BASE_W{1'b0}}}) | 64'hABC, 1'b0);
    drive_item(OP_FREE, 1, page_addr(0), 1'b0);     // already free
    drive_item(OP_ALLOC, 101, '0, 1'b0);
    drive_item(OP_FREE, 8191, '1, 1'b0);
    drive_item(OP_FREE, POOL_PAGES, page_addr(0), 1'b0);
    drive_item(OP_ALLOC, POOL_PAGES, '0, 1'b0);     // whole pool in one run
    drive_item(OP_FREE, POOL_PAGES, page_addr(0), 1'b0);
    drive_item(OP_ALLOC, 64, '0, 1'b0);             // exactly one map word
    drive_item(OP_ALLOC, 1, '0, 1'b0);
    drive_item(OP_FREE, 5, page_addr(10), 1'b0);
    drive_item(OP_ALLOC, 3, '0, 1'b0);              // first fit lands in hole
    drive_item(OP_ALLOC, 7, '0, 1'b0);              // hole too small now
    drive_item(OP_FREE, POOL_PAGES, page_addr(0), 1'b0);
  endtask

  // Mostly allocs and frees of held runs, plus partial frees and noise.
  task automatic run_random(input int n, input bit quiet);
    int unsigned       pick;
    int unsigned       cnt;
    int unsigned       slot;
    logic [ADDR_W-1:0] addr;
    run_t              held;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      addr = {$urandom, $urandom};
      if (held_runs.size() == 0 || pick < 55) begin
        pick = $urandom_range(99);
        if (pick < 65)      cnt = $urandom_range(1, 16);
        else if (pick < 85) cnt = $urandom_range(17, 256);
        else if (pick < 95) cnt = $urandom_range(257, POOL_PAGES);
        else                cnt = $urandom_range(0, 8191);
        drive_item(OP_ALLOC, cnt, addr, quiet);
      end else if (pick < 85) begin
        slot = $urandom_range(held_runs.size() - 1);
        held = held_runs[slot];
        held_runs.delete(slot);
        cnt  = held.pages;
        addr = held.base_addr;
        if (pick < 62) cnt = $urandom_range(1, held.pages);   // prefix only
        if ($urandom_range(3) == 0) addr = addr | 64'($urandom_range(4095));
        if ($urandom_range(4) == 0) addr = addr & ~{WIN_W'('1), {BASE_W{1'b0}}};
        drive_item(OP_FREE, cnt, addr, quiet);
      end else if (pick < 93) begin
        drive_item(OP_FREE, $urandom_range(0, 300),
                   page_addr($urandom_range(0, POOL_PAGES + 100)), quiet);
      end else begin
        drive_item(OP_FREE, $urandom_range(0, 8191), addr, quiet);
      end
    end
  endtask

  initial begin
    start           = 1'b0;
    operation       = OP_ALLOC;
    page_count      = '0;
    release_address = '0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_POOL_BASE;
    cfg_data        = '0;
    cur_base        = '0;
    cur_win         = WINDOW_RESET;
    rst_n           = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int phase = 0; phase < PHASES; phase++) begin
      // register settings: the reset window, both extremes, then random
      case (phase)
        0: begin cur_base = 48'h0000_4000_0000; cur_win = WINDOW_RESET; end
        1: begin cur_base = '1;                 cur_win = '1;           end
        2: begin cur_base = '0;                 cur_win = '0;           end
        3: begin cur_base = {$urandom, 4'h0, 12'h0}; cur_win = 16'($urandom); end
        default: begin
          cur_base = 48'({$urandom, $urandom});
          cur_win  = 16'($urandom);
        end
      endcase
      settle();
      // junk above the register width must be dropped by the block
      write_reg(CFG_POOL_BASE, {16'($urandom), cur_base});
      write_reg(CFG_WINDOW, {$urandom, 16'($urandom), cur_win});
      if (phase == 0) begin
        run_directed();
        settle();
        held_runs.delete();
      end
      // second setting runs without sender gaps at all
      run_random(PHASE_ITEMS, phase == 1);
      drive_item(OP_FREE, POOL_PAGES, page_addr(0), 1'b0);
      settle();
      held_runs.delete();
    end

    repeat (END_PAUSE) @(negedge clk);
    $display("Ran %0d items over %0d register writes and %0d settings", item_count,
             write_count, PHASES);
    $display("Outcomes: %0d grants, %0d no-room, %0d out-of-range", grant_count,
             no_room_count, range_count);
    if (err_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Mismatches: %0d, results never seen: %0d", err_count, pending);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/cpba_pkg.sv
design/cpba_map_ram.sv
design/cpba_word_scan.sv
design/contiguous_page_bitmap_allocator.sv
dv/page_grant_checker.sv
dv/contiguous_page_bitmap_allocator_test.sv
